[hdl/assert_macros.svh]
// assertion macros for the checker file gcst_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that is also checked during reset
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/gcst_pkg.sv]
// shared types, codes and default sizes for the grid cell slot table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gcst_pkg;

    // default geometry
    localparam int DEF_GRID_WIDTH     = 64;
    localparam int DEF_GRID_HEIGHT    = 64;
    localparam int DEF_SLOTS_PER_CELL = 8;
    localparam int DEF_TILE_W         = 16;
    localparam int DEF_TILE_H         = 16;

    // field widths
    localparam int REQ_BITS    = 2;
    localparam int ID_BITS     = 32;
    localparam int POS_BITS    = 16;
    localparam int TILE_BITS   = 16;
    localparam int STATUS_BITS = 3;
    localparam int SLOT_BITS   = ID_BITS + TILE_BITS;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_MOVE   = 2'd2
    } t_req;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_OOB      = 3'd1,
        ST_PRESENT  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_DISP,
        S_OLD,
        S_NEW,
        S_DONE
    } t_state;

    // on-grid flags of the old and the new position
    typedef struct packed {
        logic old_in;
        logic new_in;
    } t_loc_flags;

    // search result over one cell row
    typedef struct packed {
        logic found;
        logic full;
    } t_row_info;

endpackage

`default_nettype wire

[hdl/gcst_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/gcst_addr.sv]
// two-stage position to cell row address unit
// depends on gcst_pkg
`timescale 1ns / 1ps
`default_nettype none

module gcst_addr #(
    parameter int GRID_WIDTH  = gcst_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = gcst_pkg::DEF_GRID_HEIGHT,
    parameter int TILE_W      = gcst_pkg::DEF_TILE_W,
    parameter int TILE_H      = gcst_pkg::DEF_TILE_H,
    parameter int ADDR_W      = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_load,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0] i_old_x,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0] i_old_y,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0] i_new_x,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0] i_new_y,
    output gcst_pkg::t_loc_flags                      o_flags,
    output logic             [ADDR_W-1:0]             o_old_addr,
    output logic             [ADDR_W-1:0]             o_new_addr
);

    // magnitude of an on-grid coordinate is below 2^(POS_BITS-1)
    localparam int MAG_W = gcst_pkg::POS_BITS - 1;
    localparam int MUL_W = gcst_pkg::POS_BITS + 1;
    localparam int PRD_W = MAG_W + MUL_W;

    // reciprocal multipliers, exact floor(v / tile) for v < 2^MAG_W
    localparam int LX = $clog2(TILE_W);
    localparam int LY = $clog2(TILE_H);
    localparam int SX = MAG_W + LX;
    localparam int SY = MAG_W + LY;
    localparam longint MXL = ((longint'(1) << SX) + longint'(TILE_W) - 1) / longint'(TILE_W);
    localparam longint MYL = ((longint'(1) << SY) + longint'(TILE_H) - 1) / longint'(TILE_H);
    localparam logic [MUL_W-1:0] MX = MUL_W'(MXL);
    localparam logic [MUL_W-1:0] MY = MUL_W'(MYL);

    localparam int LIM_X = GRID_WIDTH * TILE_W;
    localparam int LIM_Y = GRID_HEIGHT * TILE_H;
    localparam int CWX = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int CWY = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    logic [MAG_W-1:0] mag_ox, mag_oy, mag_nx, mag_ny;
    logic             old_in, new_in;

    logic [PRD_W-1:0] r_prod_ox, r_prod_oy, r_prod_nx, r_prod_ny;
    logic             r_old_in, r_new_in;

    logic [CWX-1:0]   cell_ox, cell_nx;
    logic [CWY-1:0]   cell_oy, cell_ny;

    gcst_pkg::t_loc_flags r_flags;
    logic [ADDR_W-1:0]    r_old_addr, r_new_addr;

    // truncation toward zero puts the small negatives into column or row zero
    always_comb begin
        mag_ox = i_old_x[gcst_pkg::POS_BITS-1] ? '0 : i_old_x[MAG_W-1:0];
        mag_oy = i_old_y[gcst_pkg::POS_BITS-1] ? '0 : i_old_y[MAG_W-1:0];
        mag_nx = i_new_x[gcst_pkg::POS_BITS-1] ? '0 : i_new_x[MAG_W-1:0];
        mag_ny = i_new_y[gcst_pkg::POS_BITS-1] ? '0 : i_new_y[MAG_W-1:0];
        old_in = (int'(i_old_x) > -TILE_W) && (int'(i_old_x) < LIM_X) &&
                 (int'(i_old_y) > -TILE_H) && (int'(i_old_y) < LIM_Y);
        new_in = (int'(i_new_x) > -TILE_W) && (int'(i_new_x) < LIM_X) &&
                 (int'(i_new_y) > -TILE_H) && (int'(i_new_y) < LIM_Y);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_ox <= PRD_W'(mag_ox) * PRD_W'(MX);
            r_prod_oy <= PRD_W'(mag_oy) * PRD_W'(MY);
            r_prod_nx <= PRD_W'(mag_nx) * PRD_W'(MX);
            r_prod_ny <= PRD_W'(mag_ny) * PRD_W'(MY);
            r_old_in  <= old_in;
            r_new_in  <= new_in;
        end
    end

    always_comb begin
        cell_ox = CWX'(r_prod_ox >> SX);
        cell_oy = CWY'(r_prod_oy >> SY);
        cell_nx = CWX'(r_prod_nx >> SX);
        cell_ny = CWY'(r_prod_ny >> SY);
    end

    always_ff @(posedge i_clk) begin
        r_flags.old_in <= r_old_in;
        r_flags.new_in <= r_new_in;
        r_old_addr     <= ADDR_W'(cell_ox * GRID_HEIGHT) + ADDR_W'(cell_oy);
        r_new_addr     <= ADDR_W'(cell_nx * GRID_HEIGHT) + ADDR_W'(cell_ny);
    end

    assign o_flags    = r_flags;
    assign o_old_addr = r_old_addr;
    assign o_new_addr = r_new_addr;

endmodule

`default_nettype wire

[hdl/gcst_row.sv]
// slot search and update over one cell row read from the slot memory
// depends on gcst_pkg
`timescale 1ns / 1ps
`default_nettype none

module gcst_row #(
    parameter int SLOTS = gcst_pkg::DEF_SLOTS_PER_CELL
) (
    input  wire logic [SLOTS*gcst_pkg::SLOT_BITS-1:0] i_row,
    input  wire logic [gcst_pkg::ID_BITS-1:0]         i_id,
    input  wire logic [gcst_pkg::TILE_BITS-1:0]       i_tile,
    output gcst_pkg::t_row_info                       o_info,
    output logic      [gcst_pkg::TILE_BITS-1:0]       o_found_tile,
    output logic      [SLOTS*gcst_pkg::SLOT_BITS-1:0] o_clear_row,
    output logic      [SLOTS*gcst_pkg::SLOT_BITS-1:0] o_put_row
);

    localparam int SB = gcst_pkg::SLOT_BITS;
    localparam int IB = gcst_pkg::ID_BITS;
    localparam int TB = gcst_pkg::TILE_BITS;

    logic [SLOTS-1:0] match, free;
    logic [SLOTS-1:0] match_first, free_first;
    logic [TB-1:0]    found_tile;

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            match[s] = (i_row[s*SB +: IB] == i_id);
            free[s]  = (i_row[s*SB +: IB] == '0);
        end
        // lowest set bit picks the first slot, as a linear scan would
        match_first = match & (~match + SLOTS'(1));
        free_first  = free & (~free + SLOTS'(1));

        found_tile  = '0;
        o_clear_row = i_row;
        o_put_row   = i_row;
        for (int s = 0; s < SLOTS; s++) begin
            found_tile = found_tile | ({TB{match_first[s]}} & i_row[s*SB+IB +: TB]);
            if (match_first[s]) begin
                o_clear_row[s*SB +: SB] = '0;
            end
            if (free_first[s]) begin
                o_put_row[s*SB +: SB] = {i_tile, i_id};
            end
        end

        o_info.found = |match;
        o_info.full  = ~|free;
        o_found_tile = found_tile;
    end

endmodule

`default_nettype wire

[hdl/grid_cell_slot_table.sv]
// grid cell slot table: object id and tile slots per grid cell, kept in one row memory
// depends on gcst_pkg, gcst_ram, gcst_addr, gcst_row
//
// Requests come in on the i_valid / o_stall channel (insert, remove, move by
// delta); a transaction is taken at a clock edge with i_valid high and o_stall
// low. Each request gives one result on the o_valid / i_stall channel: a status
// code and the pixel position after the request.
// Every cell is one row of the slot memory, read and written back as one word.
// A request that never touches the memory (cell off the grid, id zero, unknown
// type, a move inside one cell or between two off-grid cells) finishes in the
// S_DISP state. Insert and remove on the grid read one row and write it back
// when it changes, as does a move with only one of its two cells on the grid;
// a move between two on-grid cells reads both rows over the single read port.
// o_stall is high from acceptance until the result is registered.
// The result register holds while i_stall is high, and the next request is
// taken meanwhile; its result then waits until the register is free.
// After reset the block sweeps all GRID_WIDTH * GRID_HEIGHT rows (4096 by
// default) to zero, one row per cycle, with o_stall high.
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_slot_table #(
    parameter int GRID_WIDTH     = gcst_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT    = gcst_pkg::DEF_GRID_HEIGHT,
    parameter int SLOTS_PER_CELL = gcst_pkg::DEF_SLOTS_PER_CELL,
    parameter int TILE_W         = gcst_pkg::DEF_TILE_W,
    parameter int TILE_H         = gcst_pkg::DEF_TILE_H
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_stall,
    input  wire logic        [gcst_pkg::REQ_BITS-1:0]    i_req_type,
    input  wire logic        [gcst_pkg::ID_BITS-1:0]     i_object_id,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0]    i_pos_x,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0]    i_pos_y,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0]    i_delta_x,
    input  wire logic signed [gcst_pkg::POS_BITS-1:0]    i_delta_y,
    input  wire logic        [gcst_pkg::TILE_BITS-1:0]   i_tile_index,
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic             [gcst_pkg::STATUS_BITS-1:0] o_status,
    output logic signed      [gcst_pkg::POS_BITS-1:0]    o_new_pos_x,
    output logic signed      [gcst_pkg::POS_BITS-1:0]    o_new_pos_y
);

    localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W  = SLOTS_PER_CELL * gcst_pkg::SLOT_BITS;
    localparam int PB     = gcst_pkg::POS_BITS;

    gcst_pkg::t_state  r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    gcst_pkg::t_status r_status, n_status;

    // request held for the whole transaction; a move takes over the tile it lifts out
    logic [gcst_pkg::REQ_BITS-1:0]  r_type;
    logic [gcst_pkg::ID_BITS-1:0]   r_id;
    logic signed [PB-1:0]           r_nx, r_ny;
    logic [gcst_pkg::TILE_BITS-1:0] r_tile, n_tile;

    // result register
    logic                           r_ovalid;
    gcst_pkg::t_status              r_ostatus;
    logic signed [PB-1:0]           r_onx, r_ony;

    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic signed [PB-1:0] nx_calc, ny_calc;

    gcst_pkg::t_loc_flags flags;
    logic [ADDR_W-1:0]    old_addr, new_addr;

    logic                 ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
    logic [ROW_W-1:0]     ram_wr_data, ram_rd_data;

    gcst_pkg::t_row_info            row_info;
    logic [gcst_pkg::TILE_BITS-1:0] found_tile;
    logic [ROW_W-1:0]               clear_row, put_row;

    logic              fin;
    gcst_pkg::t_status fin_status;
    logic              is_move, is_ins_rem, id_ok;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_ovalid || !i_stall;
    assign nx_calc   = (i_req_type == gcst_pkg::REQ_MOVE) ? i_pos_x + i_delta_x : i_pos_x;
    assign ny_calc   = (i_req_type == gcst_pkg::REQ_MOVE) ? i_pos_y + i_delta_y : i_pos_y;

    gcst_addr #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .TILE_W     (TILE_W),
        .TILE_H     (TILE_H),
        .ADDR_W     (ADDR_W)
    ) u_addr (
        .i_clk     (i_clk),
        .i_load    (in_accept),
        .i_old_x   (i_pos_x),
        .i_old_y   (i_pos_y),
        .i_new_x   (nx_calc),
        .i_new_y   (ny_calc),
        .o_flags   (flags),
        .o_old_addr(old_addr),
        .o_new_addr(new_addr)
    );

    gcst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    gcst_row #(
        .SLOTS(SLOTS_PER_CELL)
    ) u_row (
        .i_row       (ram_rd_data),
        .i_id        (r_id),
        .i_tile      (r_tile),
        .o_info      (row_info),
        .o_found_tile(found_tile),
        .o_clear_row (clear_row),
        .o_put_row   (put_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gcst_pkg::S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_tile   <= n_tile;
        if (in_accept) begin
            r_type <= i_req_type;
            r_id   <= i_object_id;
            r_nx   <= nx_calc;
            r_ny   <= ny_calc;
        end
        if (out_load) begin
            r_ostatus <= n_status;
            r_onx     <= r_nx;
            r_ony     <= r_ny;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_status    = r_status;
        n_tile      = r_tile;
        ram_wr_en   = 1'b0;
        ram_wr_addr = old_addr;
        ram_wr_data = put_row;
        ram_rd_en   = 1'b0;
        ram_rd_addr = old_addr;
        fin         = 1'b0;
        fin_status  = gcst_pkg::ST_OK;
        out_load    = 1'b0;

        is_move    = (r_type == gcst_pkg::REQ_MOVE);
        is_ins_rem = (r_type == gcst_pkg::REQ_INSERT) || (r_type == gcst_pkg::REQ_REMOVE);
        id_ok      = (r_id != '0);

        unique case (r_state)
            gcst_pkg::S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr;
                ram_wr_data = '0;
                n_clr       = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(CELLS - 1)) begin
                    n_state = gcst_pkg::S_IDLE;
                end
            end
            gcst_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = gcst_pkg::S_ADDR;
                    n_tile  = i_tile_index;
                end
            end
            gcst_pkg::S_ADDR: begin
                n_state = gcst_pkg::S_DISP;
            end
            gcst_pkg::S_DISP: begin
                priority if (!id_ok || !(is_move || is_ins_rem)) begin
                    fin = 1'b1;
                end else if (is_ins_rem) begin
                    if (flags.old_in) begin
                        ram_rd_en = 1'b1;
                        n_state   = gcst_pkg::S_OLD;
                    end else begin
                        fin        = 1'b1;
                        fin_status = gcst_pkg::ST_OOB;
                    end
                end else if (flags.old_in && flags.new_in && old_addr == new_addr) begin
                    // move inside one cell leaves the table alone
                    fin = 1'b1;
                end else if (flags.old_in) begin
                    ram_rd_en = 1'b1;
                    n_state   = gcst_pkg::S_OLD;
                end else if (flags.new_in) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = new_addr;
                    n_state     = gcst_pkg::S_NEW;
                end else begin
                    fin        = 1'b1;
                    fin_status = gcst_pkg::ST_OOB;
                end
            end
            gcst_pkg::S_OLD: begin
                priority if (r_type == gcst_pkg::REQ_INSERT) begin
                    fin = 1'b1;
                    priority if (row_info.found) begin
                        fin_status = gcst_pkg::ST_PRESENT;
                    end else if (row_info.full) begin
                        fin_status = gcst_pkg::ST_FULL;
                    end else begin
                        ram_wr_en = 1'b1;
                    end
                end else if (r_type == gcst_pkg::REQ_REMOVE) begin
                    fin         = 1'b1;
                    ram_wr_data = clear_row;
                    if (row_info.found) begin
                        ram_wr_en = 1'b1;
                    end else begin
                        fin_status = gcst_pkg::ST_NOTFOUND;
                    end
                end else begin
                    // move: lift the old entry out and carry its tile along
                    ram_wr_data = clear_row;
                    if (row_info.found) begin
                        ram_wr_en = 1'b1;
                        n_tile    = found_tile;
                    end
                    if (flags.new_in) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = new_addr;
                        n_state     = gcst_pkg::S_NEW;
                    end else begin
                        fin        = 1'b1;
                        fin_status = gcst_pkg::ST_OOB;
                    end
                end
            end
            gcst_pkg::S_NEW: begin
                fin         = 1'b1;
                ram_wr_addr = new_addr;
                priority if (row_info.found) begin
                    fin_status = gcst_pkg::ST_PRESENT;
                end else if (row_info.full) begin
                    fin_status = gcst_pkg::ST_FULL;
                end else begin
                    ram_wr_en = 1'b1;
                end
            end
            gcst_pkg::S_DONE: begin
                fin        = 1'b1;
                fin_status = r_status;
            end
            default: begin
                n_state = gcst_pkg::S_IDLE;
            end
        endcase

        // result goes straight to the output register when it is free
        if (fin) begin
            n_status = fin_status;
            if (out_free) begin
                out_load = 1'b1;
                n_state  = gcst_pkg::S_IDLE;
            end else begin
                n_state = gcst_pkg::S_DONE;
            end
        end
    end

    assign o_stall     = (r_state != gcst_pkg::S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_new_pos_x = r_onx;
    assign o_new_pos_y = r_ony;

endmodule

`default_nettype wire

[hdl/gcst_checker.sv]
// port-level checker for the grid cell slot table, bound to the top level
// depends on assert_macros.svh, gcst_pkg and grid_cell_slot_table
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gcst_checker #(
    parameter int PB = gcst_pkg::POS_BITS
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_stall,
    input wire logic                                 o_valid,
    input wire logic                                 i_stall,
    input wire logic [gcst_pkg::STATUS_BITS-1:0]     o_status,
    input wire logic [PB-1:0]                        o_new_pos_x,
    input wire logic [PB-1:0]                        o_new_pos_y
);

    // a stalled result holds its payload
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_new_pos_x) && $stable(o_new_pos_y), "result changed while stalled")

    // one request at a time: the input side stalls right after a transaction
    `ASSERT_CLK(a_accept_stall, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "second request taken while busy")

    // no result can show up in the cycle right after a request is taken
    `ASSERT_CLK(a_min_latency, i_clk, i_rst_n, i_valid && !o_stall && !o_valid |=> !o_valid, "result too early")

    // reset starts the clearing sweep with no pending result
    `ASSERT_CLK_NORST(a_reset_clear, i_clk, !i_rst_n |=> o_stall && !o_valid, "not busy after reset")

endmodule

bind grid_cell_slot_table gcst_checker u_gcst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_new_pos_x(o_new_pos_x),
    .o_new_pos_y(o_new_pos_y)
);

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for grid_cell_slot_table: directed table, then random requests
// depends on gcst_pkg and grid_cell_slot_table; results checked against an in-bench slot model
`timescale 1ns / 1ps

module tb;
    import gcst_pkg::*;

    localparam int GW        = DEF_GRID_WIDTH;
    localparam int GH        = DEF_GRID_HEIGHT;
    localparam int SPC       = DEF_SLOTS_PER_CELL;
    localparam int TW        = DEF_TILE_W;
    localparam int TH        = DEF_TILE_H;
    localparam int NUM_SLOTS = GW * GH * SPC;
    localparam int N_RANDOM  = 1950;
    localparam int POOL      = 24;
    localparam int N_PLAN    = 29;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_BITS-1:0]     status;
        logic signed [POS_BITS-1:0] x;
        logic signed [POS_BITS-1:0] y;
    } t_outcome;

    typedef struct {
        logic [REQ_BITS-1:0]        rt;
        logic [ID_BITS-1:0]         id;
        logic signed [POS_BITS-1:0] px;
        logic signed [POS_BITS-1:0] py;
        logic signed [POS_BITS-1:0] dx;
        logic signed [POS_BITS-1:0] dy;
        logic [TILE_BITS-1:0]       tile;
        bit                         fixed;
        logic [STATUS_BITS-1:0]     st;
        logic signed [POS_BITS-1:0] ex;
        logic signed [POS_BITS-1:0] ey;
    } t_row;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic                        o_stall;
    logic [REQ_BITS-1:0]         i_req_type   = '0;
    logic [ID_BITS-1:0]          i_object_id  = '0;
    logic signed [POS_BITS-1:0]  i_pos_x      = '0;
    logic signed [POS_BITS-1:0]  i_pos_y      = '0;
    logic signed [POS_BITS-1:0]  i_delta_x    = '0;
    logic signed [POS_BITS-1:0]  i_delta_y    = '0;
    logic [TILE_BITS-1:0]        i_tile_index = '0;
    logic                        o_valid;
    logic                        i_stall      = 1'b0;
    logic [STATUS_BITS-1:0]      o_status;
    logic signed [POS_BITS-1:0]  o_new_pos_x;
    logic signed [POS_BITS-1:0]  o_new_pos_y;

    grid_cell_slot_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_object_id (i_object_id),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_delta_x   (i_delta_x),
        .i_delta_y   (i_delta_y),
        .i_tile_index(i_tile_index),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_new_pos_x (o_new_pos_x),
        .o_new_pos_y (o_new_pos_y)
    );

    always #4 i_clk = ~i_clk;

    // model of the slot store
    logic [ID_BITS-1:0]   slot_ids   [NUM_SLOTS];
    logic [TILE_BITS-1:0] slot_tiles [NUM_SLOTS];

    t_outcome pending_outcomes [$];
    int       errors     = 0;
    int       send_idle  = 32;
    int       recv_idle  = 49;
    bit       cur_fixed  = 1'b0;
    t_outcome cur_exp    = '0;

    // cell of a pixel position, truncating toward zero like the block
    function automatic bit cell_of(input logic signed [POS_BITS-1:0] px,
                                   input logic signed [POS_BITS-1:0] py, output int base);
        int cx;
        int cy;
        cx = int'(px) / TW;
        cy = int'(py) / TH;
        base = (cx * GH + cy) * SPC;
        return !(cx < 0 || cx >= GW || cy < 0 || cy >= GH);
    endfunction

    function automatic int find_slot(input int base, input logic [ID_BITS-1:0] id);
        for (int s = 0; s < SPC; s++)
            if (slot_ids[base + s] == id) return s;
        return -1;
    endfunction

    function automatic t_status place_entry(input int base, input logic [ID_BITS-1:0] id,
                                            input logic [TILE_BITS-1:0] tile);
        int s;
        if (find_slot(base, id) >= 0) return ST_PRESENT;
        s = find_slot(base, '0);
        if (s < 0) return ST_FULL;
        slot_ids[base + s]   = id;
        slot_tiles[base + s] = tile;
        return ST_OK;
    endfunction

    // updates the slot model and gives the result the block should return
    function automatic t_outcome apply_request(input t_row it);
        t_outcome                   r;
        logic signed [POS_BITS-1:0] qx;
        logic signed [POS_BITS-1:0] qy;
        logic [TILE_BITS-1:0]       carried;
        int                         ob;
        int                         nb;
        int                         s;
        bit                         new_in;
        r.status = ST_OK;
        r.x      = it.px;
        r.y      = it.py;
        carried  = it.tile;
        if (it.rt == REQ_INSERT || it.rt == REQ_REMOVE) begin
            if (it.id != '0) begin
                if (!cell_of(it.px, it.py, ob)) begin
                    r.status = ST_OOB;
                end else if (it.rt == REQ_INSERT) begin
                    r.status = place_entry(ob, it.id, it.tile);
                end else begin
                    s = find_slot(ob, it.id);
                    if (s < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        slot_ids[ob + s]   = '0;
                        slot_tiles[ob + s] = '0;
                    end
                end
            end
        end else if (it.rt == REQ_MOVE) begin
            qx  = it.px + it.dx;
            qy  = it.py + it.dy;
            r.x = qx;
            r.y = qy;
            if (it.id != '0) begin
                new_in = cell_of(qx, qy, nb);
                if (int'(it.px) / TW == int'(qx) / TW && int'(it.py) / TH == int'(qy) / TH) begin
                    r.status = new_in ? ST_OK : ST_OOB;
                end else begin
                    if (cell_of(it.px, it.py, ob)) begin
                        s = find_slot(ob, it.id);
                        if (s >= 0) begin
                            carried            = slot_tiles[ob + s];
                            slot_ids[ob + s]   = '0;
                            slot_tiles[ob + s] = '0;
                        end
                    end
                    r.status = new_in ? place_entry(nb, it.id, carried) : ST_OOB;
                end
            end
        end
        return r;
    endfunction

    // result check first, then the prediction for a transaction taken at this edge
    always @(posedge i_clk) begin : check_and_predict
        t_outcome want;
        t_outcome got;
        t_row     taken;
        if (i_rst_n) begin
            if (o_valid && i_stall === 1'b0) begin
                got = '{o_status, o_new_pos_x, o_new_pos_y};
                if (pending_outcomes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status %0d x %0d y %0d",
                                 got.status, got.x, got.y);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status || got.x !== want.x || got.y !== want.y) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: status %0d/%0d x %0d/%0d y %0d/%0d (exp/got)",
                                     want.status, got.status, want.x, got.x, want.y, got.y);
                    end
                end
            end
            if (i_valid && o_stall === 1'b0) begin
                taken = '{i_req_type, i_object_id, i_pos_x, i_pos_y, i_delta_x, i_delta_y,
                          i_tile_index, 1'b0, ST_OK, 0, 0};
                want = apply_request(taken);
                pending_outcomes.push_back(cur_fixed ? cur_exp : want);
            end
        end
    end

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_idle);

    task automatic drive_request(input t_row it);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_req_type   <= it.rt;
        i_object_id  <= it.id;
        i_pos_x      <= it.px;
        i_pos_y      <= it.py;
        i_delta_x    <= it.dx;
        i_delta_y    <= it.dy;
        i_tile_index <= it.tile;
        cur_fixed    <= it.fixed;
        cur_exp      <= '{it.st, it.ex, it.ey};
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // mostly around the first two cells so they fill up, sometimes near the far edge
    function automatic logic signed [POS_BITS-1:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 40) return POS_BITS'($urandom_range(46) - 15);
        if (r < 70) return POS_BITS'($urandom_range(79) - 16);
        if (r < 85) return POS_BITS'($urandom_range(1040, 1000));
        return POS_BITS'($urandom);
    endfunction

    function automatic logic signed [POS_BITS-1:0] pick_delta();
        int r;
        r = $urandom_range(99);
        if (r < 45) return POS_BITS'($urandom_range(40) - 20);
        if (r < 65) return POS_BITS'(($urandom_range(1) ? 16 : 32) * ($urandom_range(1) ? 1 : -1));
        if (r < 80) return '0;
        return POS_BITS'($urandom);
    endfunction

    t_row plan [N_PLAN] = '{
        // rt          id             px      py     dx    dy    tile   fix st           ex      ey
        '{REQ_REMOVE,  32'd5,         0,      0,     0,    0,    16'h0,    1, ST_NOTFOUND, 0,      0},
        '{REQ_INSERT,  32'd5,         0,      0,     0,    0,    16'hFFFF, 1, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd5,         15,     15,    0,    0,    16'h1,    1, ST_PRESENT,  15,     15},
        '{REQ_INSERT,  32'hFFFF_FFFF, 1023,   1023,  0,    0,    16'h0,    1, ST_OK,       1023,   1023},
        '{REQ_INSERT,  32'd6,         1024,   0,     0,    0,    16'h3,    1, ST_OOB,      1024,   0},
        // small negative positions still fall into cell zero
        '{REQ_INSERT,  32'd7,         -15,    -15,   0,    0,    16'h8001, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd8,         -16,    5,     0,    0,    16'h2,    1, ST_OOB,      -16,    5},
        '{REQ_REMOVE,  32'd8,         -32768, 32767, 0,    0,    16'h0,    1, ST_OOB,      -32768, 32767},
        '{REQ_INSERT,  32'd10,        3,      4,     0,    0,    16'h1234, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd11,        3,      4,     0,    0,    16'h5678, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd12,        3,      4,     0,    0,    16'h0F0F, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd13,        3,      4,     0,    0,    16'hF0F0, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd14,        3,      4,     0,    0,    16'h5555, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd15,        3,      4,     0,    0,    16'hAAAA, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd16,        8,      8,     0,    0,    16'h7,    1, ST_FULL,     8,      8},
        '{REQ_MOVE,    32'd5,         0,      0,     16,   0,    16'h0,    0, ST_OK,       0,      0},
        '{REQ_MOVE,    32'd10,        3,      4,     1,    1,    16'h0,    0, ST_OK,       0,      0},
        '{REQ_MOVE,    32'd11,        3,      4,     -20,  0,    16'h0,    0, ST_OK,       0,      0},
        // move of an object that was never inserted
        '{REQ_MOVE,    32'd99,        100,    100,   100,  0,    16'h00AA, 0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd20,        1,      1,     0,    0,    16'h20,   0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd21,        2,      2,     0,    0,    16'h21,   0, ST_OK,       0,      0},
        '{REQ_MOVE,    32'd99,        200,    100,   -200, -100, 16'h0,    0, ST_OK,       0,      0},
        '{REQ_INSERT,  32'd7,         16,     16,    0,    0,    16'h77,   0, ST_OK,       0,      0},
        '{REQ_MOVE,    32'd7,         0,      0,     16,   16,   16'h0,    0, ST_OK,       0,      0},
        '{REQ_MOVE,    32'd0,         32767,  -32768, 1,   -1,   16'h0,    1, ST_OK,       -32768, 32767},
        '{REQ_REMOVE,  32'd0,         5,      5,     0,    0,    16'h0,    1, ST_OK,       5,      5},
        '{REQ_UNUSED,  32'd5,         5,      5,     7,    7,    16'h0,    1, ST_OK,       5,      5},
        '{REQ_MOVE,    32'd12,        -20,    0,     1,    0,    16'h0,    1, ST_OOB,      -19,    0},
        '{REQ_MOVE,    32'd13,        3,      4,     0,    0,    16'h0,    1, ST_OK,       3,      4}
    };

    initial begin : stimulus
        bit                         known [POOL];
        logic signed [POS_BITS-1:0] kx    [POOL];
        logic signed [POS_BITS-1:0] ky    [POOL];
        t_row                       it;
        int                         k;
        int                         r;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ids[i]   = '0;
            slot_tiles[i] = '0;
        end
        for (int i = 0; i < POOL; i++) known[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_PLAN; i++) drive_request(plan[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle = 49;
                recv_idle = 32;
            end else if (i == 2 * N_RANDOM / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            it       = '{REQ_INSERT, '0, '0, '0, '0, '0, '0, 1'b0, ST_OK, 0, 0};
            k        = $urandom_range(POOL - 1);
            r        = $urandom_range(99);
            it.id    = (k < 16) ? ID_BITS'(k + 1) : ID_BITS'(32'hFFFF_FFE8 + k);
            if (r < 8) begin
                it.id = $urandom;
                k     = -1;
            end else if (r < 10) begin
                it.id = '0;
                k     = -1;
            end
            r = $urandom_range(99);
            it.rt = (r < 35) ? REQ_INSERT : (r < 60) ? REQ_REMOVE : (r < 97) ? REQ_MOVE
                                                                              : REQ_UNUSED;
            it.px   = pick_coord();
            it.py   = pick_coord();
            it.dx   = pick_delta();
            it.dy   = pick_delta();
            it.tile = $urandom;
            // follow the tracked position so most removes and moves find their entry
            if (k >= 0 && known[k] && it.rt != REQ_INSERT && $urandom_range(99) < 80) begin
                it.px = kx[k];
                it.py = ky[k];
            end
            if (k >= 0) begin
                if (it.rt == REQ_INSERT) begin
                    known[k] = 1'b1;
                    kx[k]    = it.px;
                    ky[k]    = it.py;
                end else if (it.rt == REQ_REMOVE) begin
                    known[k] = 1'b0;
                end else if (it.rt == REQ_MOVE) begin
                    known[k] = 1'b1;
                    kx[k]    = it.px + it.dx;
                    ky[k]    = it.py + it.dy;
                end
            end
            drive_request(it);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
